FILE: sv/magnetometer_hard_soft_iron_calibration_macros.svh
// Assertion macros shared by the calibration block.
// Each macro expects clk and arst_n in scope.
`ifndef MAGNETOMETER_HARD_SOFT_IRON_CALIBRATION_MACROS_SVH
`define MAGNETOMETER_HARD_SOFT_IRON_CALIBRATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHSI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mhsi_pkg.sv
`timescale 1ns / 1ps
package mhsi_pkg;

	localparam int SCALE_FRACTION_BITS_DEF = 12;
	localparam int RAW_W = 16;
	localparam int MAG_W = 26;
	localparam int SCL_W = 16;
	localparam int CNT_W = 32;
	// Divider widths: the sample quotient needs at most 32 + 8 dividend bits.
	localparam int DIV_W = 40;
	localparam int DVS_W = 18;

	localparam logic [DVS_W-1:0] SENS_LOW  = 18'd12000;
	localparam logic [DVS_W-1:0] SENS_HIGH = 18'd3000;
	localparam logic signed [RAW_W-1:0] MIN_RESET = 16'sh7fff;
	localparam logic signed [RAW_W-1:0] MAX_RESET = 16'sh8000;

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_START  = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		K_SAMPLE = 2'd0,
		K_START  = 2'd1,
		K_FINISH = 2'd2,
		K_NOP    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic signed [RAW_W-1:0] raw_x;
		logic signed [RAW_W-1:0] raw_y;
		logic signed [RAW_W-1:0] raw_z;
	} cmd_t;

	// Head of the command queue as seen by the back end.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhs_t;

endpackage

FILE: sv/mhsi_front.sv
`timescale 1ns / 1ps
module mhsi_front import mhsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] action,
	input  logic signed [RAW_W-1:0] raw_x,
	input  logic signed [RAW_W-1:0] raw_y,
	input  logic signed [RAW_W-1:0] raw_z,
	output qhs_t head,
	input  logic pop
);

	cmd_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;
	kind_t kind;
	logic push;
	logic take;

	// Decode the action into the command kind the back end executes.
	always_comb begin
		case (action_t'(action))
			ACT_SAMPLE: kind = K_SAMPLE;
			ACT_START:  kind = K_START;
			ACT_FINISH: kind = K_FINISH;
			default:    kind = K_NOP;
		endcase
	end

	assign in_stall = (fill_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign take = pop && (fill_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{kind: kind, raw_x: raw_x, raw_y: raw_y, raw_z: raw_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, take};
		end
	end

	assign head.valid = (fill_q != 2'd0);
	assign head.cmd = ent_q[rd_ptr_q];

endmodule

FILE: sv/mhsi_div.sv
`timescale 1ns / 1ps
module mhsi_div import mhsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic busy,
	output logic done,
	output logic [DIV_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic ge;

	// Restoring division, one quotient bit per cycle, MSB first.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign ge = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q && (step_q != '0)) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIV_W);
		end else if (busy_q) begin
			if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (step_q == '0);
	assign quotient = quo_q;

endmodule

FILE: sv/mhsi_back.sv
`timescale 1ns / 1ps
`include "magnetometer_hard_soft_iron_calibration_macros.svh"
module mhsi_back import mhsi_pkg::*; #(
	parameter int SCALE_FRACTION_BITS = SCALE_FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic range_high,
	input  qhs_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [MAG_W-1:0] mag_x,
	output logic signed [MAG_W-1:0] mag_y,
	output logic signed [MAG_W-1:0] mag_z,
	output logic sample_valid,
	output logic calibrating_now,
	output logic calibration_done,
	output logic [CNT_W-1:0] samples_seen
);

	localparam int SHIFT = 16 - SCALE_FRACTION_BITS;
	localparam int ONE_I = 1 << SCALE_FRACTION_BITS;
	localparam logic [SCL_W-1:0] UNITY = (ONE_I > 65535) ? 16'hFFFF : SCL_W'(ONE_I);
	localparam logic [DIV_W-1:0] MAG_HALF = DIV_W'(1) << (MAG_W - 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_SDIV  = 8'b0000_0100,
		S_SWAIT = 8'b0000_1000,
		S_FPREP = 8'b0001_0000,
		S_FSEL  = 8'b0010_0000,
		S_FWAIT = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [1:0] axis_q;
	cmd_t cmd_q;
	logic signed [RAW_W-1:0] min_q [3];
	logic signed [RAW_W-1:0] max_q [3];
	logic signed [RAW_W-1:0] off_q [3];
	logic [SCL_W-1:0] scl_q [3];
	logic signed [RAW_W:0] rng_q [3];
	logic signed [RAW_W+2:0] sum_q;
	logic [31:0] prod_q;
	logic neg_q;
	logic [MAG_W-1:0] mag_q [3];
	logic tracking_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic signed [MAG_W-1:0] mag_x_q;
	logic signed [MAG_W-1:0] mag_y_q;
	logic signed [MAG_W-1:0] mag_z_q;
	logic sample_valid_q;
	logic calibrating_q;
	logic cal_done_q;
	logic [CNT_W-1:0] seen_q;

	logic signed [RAW_W-1:0] raw_a [3];
	logic signed [RAW_W-1:0] raw_sel;
	logic signed [RAW_W:0] diff;
	logic [RAW_W:0] absd;
	logic signed [RAW_W:0] rng_sel;
	logic signed [RAW_W:0] mid [3];
	logic signed [RAW_W-1:0] off_new [3];
	logic fin_go;
	logic div_start;
	logic div_busy;
	logic div_done;
	logic [DIV_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic [DIV_W-1:0] div_quo;
	logic [DIV_W-1:0] quo_neg;
	logic [MAG_W-1:0] mag_sat;
	logic [SCL_W-1:0] scale_sat;
	logic is_samp;
	logic is_start;
	logic is_fin;
	logic trk_nx;
	logic dn_nx;
	logic can_out;
	logic load;
	logic last_axis;
	logic fin_load;
	logic fin_flags;
	logic word_idle;
	logic mags_zero;

	assign raw_a[0] = cmd_q.raw_x;
	assign raw_a[1] = cmd_q.raw_y;
	assign raw_a[2] = cmd_q.raw_z;

	always_comb begin
		case (axis_q)
			2'd0: raw_sel = cmd_q.raw_x;
			2'd1: raw_sel = cmd_q.raw_y;
			default: raw_sel = cmd_q.raw_z;
		endcase
	end

	// Offset-removed magnitude; the sign is put back after the division.
	assign diff = {raw_sel[RAW_W-1], raw_sel} - {off_q[axis_q][RAW_W-1], off_q[axis_q]};
	assign absd = diff[RAW_W] ? (-diff) : diff;
	assign rng_sel = rng_q[axis_q];
	assign fin_go = (rng_sel > 0) && (sum_q > 0);

	// Offset is the midpoint, truncated toward zero.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mid[i] = {max_q[i][RAW_W-1], max_q[i]} + {min_q[i][RAW_W-1], min_q[i]};
			off_new[i] = RAW_W'((mid[i] + {{RAW_W{1'b0}}, mid[i][RAW_W]}) >>> 1);
		end
	end

	assign div_start = (state_q == S_SDIV) || ((state_q == S_FSEL) && fin_go);
	assign div_dvd = (state_q == S_SDIV) ? (DIV_W'(prod_q) << SHIFT)
		: (DIV_W'(sum_q[RAW_W+1:0]) << SCALE_FRACTION_BITS);
	assign div_dvs = (state_q == S_SDIV) ? (range_high ? SENS_HIGH : SENS_LOW)
		: (DVS_W'({rng_sel[RAW_W-1:0], 1'b0}) + DVS_W'(rng_sel[RAW_W-1:0]));

	mhsi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign quo_neg = -div_quo;
	always_comb begin
		if (neg_q) begin
			mag_sat = (div_quo > MAG_HALF) ? {1'b1, {(MAG_W-1){1'b0}}} : quo_neg[MAG_W-1:0];
		end else begin
			mag_sat = (div_quo >= MAG_HALF) ? {1'b0, {(MAG_W-1){1'b1}}} : div_quo[MAG_W-1:0];
		end
	end
	assign scale_sat = (|div_quo[DIV_W-1:SCL_W]) ? {SCL_W{1'b1}} : div_quo[SCL_W-1:0];

	assign is_samp = (cmd_q.kind == K_SAMPLE);
	assign is_start = (cmd_q.kind == K_START);
	assign is_fin = (cmd_q.kind == K_FINISH);
	assign trk_nx = is_start ? 1'b1 : (is_fin ? 1'b0 : tracking_q);
	assign dn_nx = is_start ? 1'b0 : ((is_fin && tracking_q) ? 1'b1 : done_q);
	assign can_out = !out_valid_q || !out_stall;
	assign load = (state_q == S_DONE) && can_out;
	assign pop = (state_q == S_IDLE) && head.valid;
	assign last_axis = (axis_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= 2'd0;
			tracking_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				min_q[i] <= MIN_RESET;
				max_q[i] <= MAX_RESET;
				off_q[i] <= '0;
				scl_q[i] <= UNITY;
			end
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						axis_q <= 2'd0;
						case (head.cmd.kind)
							K_SAMPLE: state_q <= S_MUL;
							K_FINISH: state_q <= tracking_q ? S_FPREP : S_DONE;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_MUL: state_q <= S_SDIV;
				S_SDIV: state_q <= S_SWAIT;
				S_SWAIT: begin
					if (div_done) begin
						axis_q <= axis_q + 2'd1;
						state_q <= last_axis ? S_DONE : S_MUL;
					end
				end
				S_FPREP: begin
					for (int i = 0; i < 3; i++) begin
						off_q[i] <= off_new[i];
					end
					state_q <= S_FSEL;
				end
				S_FSEL: begin
					if (fin_go) begin
						state_q <= S_FWAIT;
					end else begin
						// A positive range with a non-positive sum gives a zero scale.
						if (rng_sel > 0) begin
							scl_q[axis_q] <= '0;
						end
						axis_q <= axis_q + 2'd1;
						state_q <= last_axis ? S_DONE : S_FSEL;
					end
				end
				S_FWAIT: begin
					if (div_done) begin
						scl_q[axis_q] <= scale_sat;
						axis_q <= axis_q + 2'd1;
						state_q <= last_axis ? S_DONE : S_FSEL;
					end
				end
				S_DONE: begin
					if (can_out) begin
						tracking_q <= trk_nx;
						done_q <= dn_nx;
						cnt_q <= cnt_q + CNT_W'(is_samp);
						for (int i = 0; i < 3; i++) begin
							if (is_start) begin
								min_q[i] <= MIN_RESET;
								max_q[i] <= MAX_RESET;
							end else if (is_samp && tracking_q) begin
								if (raw_a[i] < min_q[i]) begin
									min_q[i] <= raw_a[i];
								end
								if (raw_a[i] > max_q[i]) begin
									max_q[i] <= raw_a[i];
								end
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
		end
		if (state_q == S_MUL) begin
			prod_q <= absd[RAW_W-1:0] * scl_q[axis_q];
			neg_q <= diff[RAW_W];
		end
		if ((state_q == S_SWAIT) && div_done) begin
			mag_q[axis_q] <= mag_sat;
		end
		if (state_q == S_FPREP) begin
			for (int i = 0; i < 3; i++) begin
				rng_q[i] <= {max_q[i][RAW_W-1], max_q[i]} - {min_q[i][RAW_W-1], min_q[i]};
			end
			sum_q <= ({max_q[0][RAW_W-1], max_q[0][RAW_W-1], max_q[0][RAW_W-1], max_q[0]}
				- {min_q[0][RAW_W-1], min_q[0][RAW_W-1], min_q[0][RAW_W-1], min_q[0]})
				+ ({max_q[1][RAW_W-1], max_q[1][RAW_W-1], max_q[1][RAW_W-1], max_q[1]}
				- {min_q[1][RAW_W-1], min_q[1][RAW_W-1], min_q[1][RAW_W-1], min_q[1]})
				+ ({max_q[2][RAW_W-1], max_q[2][RAW_W-1], max_q[2][RAW_W-1], max_q[2]}
				- {min_q[2][RAW_W-1], min_q[2][RAW_W-1], min_q[2][RAW_W-1], min_q[2]});
		end
		if (load) begin
			mag_x_q <= is_samp ? mag_q[0] : '0;
			mag_y_q <= is_samp ? mag_q[1] : '0;
			mag_z_q <= is_samp ? mag_q[2] : '0;
			sample_valid_q <= is_samp;
			calibrating_q <= trk_nx;
			cal_done_q <= dn_nx;
			seen_q <= cnt_q + CNT_W'(is_samp);
		end
	end

	assign out_valid = out_valid_q;
	assign mag_x = mag_x_q;
	assign mag_y = mag_y_q;
	assign mag_z = mag_z_q;
	assign sample_valid = sample_valid_q;
	assign calibrating_now = calibrating_q;
	assign calibration_done = cal_done_q;
	assign samples_seen = seen_q;

	assign fin_load = load && is_fin && tracking_q;
	assign fin_flags = !tracking_q && done_q;
	assign word_idle = out_valid_q && !sample_valid_q;
	assign mags_zero = (mag_x_q == '0) && (mag_y_q == '0) && (mag_z_q == '0);

	`MHSI_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider started while busy")
	`MHSI_ASSERT_NOW(a_out_safe, load, !(out_valid_q && out_stall), "result register overwritten")
	`MHSI_ASSERT_NEXT(a_fin_flags, fin_load, fin_flags, "finish flags wrong")
	`MHSI_ASSERT_NOW(a_mag_zero, word_idle, mags_zero, "field set on a non-sample word")

endmodule

FILE: sv/magnetometer_hard_soft_iron_calibration.sv
// A sample word runs a multiply and a division per axis before its result; a finish while
// calibrating runs a division per axis with a positive range and sum.
// Start, idle actions and a finish while not calibrating need no division.
// The back end takes one word at a time, each sample through three 40-step radix-2
// divisions; a two-word queue takes new words meanwhile.
// Reset (arst_n low, asynchronous) restores unity scales, zero offsets, empty extremes and range 0.
`timescale 1ns / 1ps
module magnetometer_hard_soft_iron_calibration import mhsi_pkg::*; #(
	parameter int SCALE_FRACTION_BITS = SCALE_FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] action,
	input  logic signed [RAW_W-1:0] raw_x,
	input  logic signed [RAW_W-1:0] raw_y,
	input  logic signed [RAW_W-1:0] raw_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [MAG_W-1:0] mag_x,
	output logic signed [MAG_W-1:0] mag_y,
	output logic signed [MAG_W-1:0] mag_z,
	output logic sample_valid,
	output logic calibrating_now,
	output logic calibration_done,
	output logic [CNT_W-1:0] samples_seen
);

	// The range register picks the sensitivity divisor: 12000 counts per gauss when low,
	// 3000 when high. Write it only while the block is idle; the block does not enforce it.
	logic range_high_q;

	// The front end decodes each word and holds it in the queue; the back end pops it
	// once the previous word has been handed to the result register.
	qhs_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_high_q <= 1'b0;
		end else if (cfg_we) begin
			range_high_q <= cfg_wdata;
		end
	end

	mhsi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.raw_x    (raw_x),
		.raw_y    (raw_y),
		.raw_z    (raw_z),
		.head     (head),
		.pop      (pop)
	);

	// The back end runs the correction per axis (multiply, then divide by the sensitivity)
	// and the finish step (midpoint offsets, then a scale division for each axis whose range
	// and sum are positive), all on a single shared divider.
	mhsi_back #(
		.SCALE_FRACTION_BITS (SCALE_FRACTION_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.range_high       (range_high_q),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.mag_x            (mag_x),
		.mag_y            (mag_y),
		.mag_z            (mag_z),
		.sample_valid     (sample_valid),
		.calibrating_now  (calibrating_now),
		.calibration_done (calibration_done),
		.samples_seen     (samples_seen)
	);

endmodule

FILE: tb/mhsi_checker.sv
`timescale 1ns / 1ps
module mhsi_checker import mhsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [1:0] action,
	input  logic signed [RAW_W-1:0] raw_x,
	input  logic signed [RAW_W-1:0] raw_y,
	input  logic signed [RAW_W-1:0] raw_z,
	input  logic out_valid,
	input  logic out_stall,
	input  logic signed [MAG_W-1:0] mag_x,
	input  logic signed [MAG_W-1:0] mag_y,
	input  logic signed [MAG_W-1:0] mag_z,
	input  logic sample_valid,
	input  logic calibrating_now,
	input  logic calibration_done,
	input  logic [CNT_W-1:0] samples_seen,
	output int errors,
	output int pending
);
	typedef struct packed {
		logic signed [MAG_W-1:0] mx;
		logic signed [MAG_W-1:0] my;
		logic signed [MAG_W-1:0] mz;
		logic sv;
		logic cal;
		logic done;
		logic [CNT_W-1:0] cnt;
	} reading_t;

	reading_t expected_readings[$];
	longint lo_ext[3], hi_ext[3], offs[3], scl[3];
	logic tracking, calibrated, rng8;
	logic [CNT_W-1:0] count;

	function automatic logic signed [MAG_W-1:0] corrected(longint raw, int i);
		longint d, den, q;
		d = raw - offs[i];
		den = (rng8 ? 3000 : 12000) * (longint'(1) << SCALE_FRACTION_BITS_DEF);
		q = (d * scl[i] * 65536) / den;
		if (q > 33554431) q = 33554431;
		if (q < -33554432) q = -33554432;
		return q[MAG_W-1:0];
	endfunction

	task automatic calibrate_step(input logic [1:0] act, input longint r[3]);
		reading_t e;
		longint span[3], total, q;
		e = '0;
		if (act == ACT_SAMPLE) begin
			e.mx = corrected(r[0], 0);
			e.my = corrected(r[1], 1);
			e.mz = corrected(r[2], 2);
			if (tracking) begin
				for (int i = 0; i < 3; i++) begin
					if (r[i] < lo_ext[i]) lo_ext[i] = r[i];
					if (r[i] > hi_ext[i]) hi_ext[i] = r[i];
				end
			end
			count++;
			e.sv = 1'b1;
		end else if (act == ACT_START) begin
			for (int i = 0; i < 3; i++) begin
				lo_ext[i] = 32767;
				hi_ext[i] = -32768;
			end
			tracking = 1'b1;
			calibrated = 1'b0;
		end else if (act == ACT_FINISH && tracking) begin
			total = 0;
			tracking = 1'b0;
			for (int i = 0; i < 3; i++) begin
				offs[i] = (hi_ext[i] + lo_ext[i]) / 2;
				span[i] = hi_ext[i] - lo_ext[i];
				total += span[i];
			end
			for (int i = 0; i < 3; i++) begin
				if (span[i] > 0) begin
					if (total <= 0) scl[i] = 0;
					else begin
						q = (total << SCALE_FRACTION_BITS_DEF) / (3 * span[i]);
						scl[i] = q > 65535 ? 65535 : q;
					end
				end
			end
			calibrated = 1'b1;
		end
		e.cal = tracking;
		e.done = calibrated;
		e.cnt = count;
		expected_readings.push_back(e);
	endtask

	assign pending = expected_readings.size();

	always @(posedge clk or negedge arst_n) begin
		reading_t e;
		longint r[3];
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lo_ext[i] = 32767;
				hi_ext[i] = -32768;
				offs[i] = 0;
				scl[i] = 1 << SCALE_FRACTION_BITS_DEF;
			end
			tracking = 0;
			calibrated = 0;
			count = '0;
			rng8 = 0;
			errors = 0;
			expected_readings.delete();
		end else begin
			if (cfg_we) rng8 = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: result word with nothing expected", $time);
					errors++;
				end else begin
					e = expected_readings.pop_front();
					if ({mag_x, mag_y, mag_z, sample_valid, calibrating_now, calibration_done,
						samples_seen} !== e) begin
						$display("%0t: mismatch expected %0d %0d %0d sv%b cal%b done%b cnt%0d",
							$time, e.mx, e.my, e.mz, e.sv, e.cal, e.done, e.cnt);
						$display("%0t:            actual %0d %0d %0d sv%b cal%b done%b cnt%0d",
							$time, mag_x, mag_y, mag_z, sample_valid, calibrating_now,
							calibration_done, samples_seen);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				r[0] = raw_x;
				r[1] = raw_y;
				r[2] = raw_z;
				calibrate_step(action, r);
			end
		end
	end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import mhsi_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_NONE;
	logic signed [RAW_W-1:0] raw_x = '0, raw_y = '0, raw_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [MAG_W-1:0] mag_x, mag_y, mag_z;
	logic sample_valid, calibrating_now, calibration_done;
	logic [CNT_W-1:0] samples_seen;
	int errors, pending;

	// Percentages for the sender gaps and the receiver stalls; the stimulus process
	// moves them from phase to phase.
	int send_gap_pct = 0;
	int stall_pct = 0;
	bit hold_off = 1'b0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	magnetometer_hard_soft_iron_calibration u_top (.*);

	mhsi_checker u_chk (.*);

	// The receiver stalls at random, and during a hold-off it stalls solidly so the
	// two-word queue fills and the block pushes back on the sender.
	always @(negedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	// Watchdog: a long run with no word moving on either channel means a hang.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("** magnetometer_hard_soft_iron_calibration: FAILED **");
			$finish;
		end
	end

	// Offers one word and holds it until the block takes it. Random gaps precede it.
	// Valid stays high on return so the next word can follow directly; callers that
	// pause drop it themselves.
	task automatic send_word(input logic [1:0] act, input logic signed [15:0] x,
		input logic signed [15:0] y, input logic signed [15:0] z);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		raw_x <= x;
		raw_y <= y;
		raw_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Raw values lean toward the rails now and then so the saturation paths are hit.
	function automatic logic signed [15:0] pick_raw();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($signed($urandom_range(400)) - 200);
			default: return 16'($urandom());
		endcase
	endfunction

	// A full calibration sweep: start, n samples, then finish.
	task automatic sweep(input int n);
		send_word(ACT_START, pick_raw(), pick_raw(), pick_raw());
		repeat (n) send_word(ACT_SAMPLE, pick_raw(), pick_raw(), pick_raw());
		send_word(ACT_FINISH, '0, '0, '0);
	endtask

	// Register writes happen only with the block drained, then a pause covers the
	// back end finishing any word still in flight.
	task automatic set_range(input logic v);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sends about n words.
	task automatic random_phase(input int n);
		int k;
		int n_s;
		k = 0;
		while (k < n) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					n_s = $urandom_range(1, 8);
					sweep(n_s);
					k += n_s + 2;
				end
				6: begin
					send_word(2'($urandom_range(3)), pick_raw(), pick_raw(), pick_raw());
					k += 1;
				end
				default: begin
					send_word(ACT_SAMPLE, pick_raw(), pick_raw(), pick_raw());
					k += 1;
				end
			endcase
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words: samples with unity scale at the rails, idle action, a finish
		// while not tracking, a finish without samples, and a restarted sweep.
		send_word(ACT_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh0000);
		send_word(ACT_SAMPLE, 16'sh8000, 16'sh7fff, -16'sd1);
		send_word(ACT_NONE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_word(ACT_FINISH, '0, '0, '0);
		send_word(ACT_START, '0, '0, '0);
		send_word(ACT_FINISH, '0, '0, '0);
		send_word(ACT_START, '0, '0, '0);
		send_word(ACT_SAMPLE, 16'sd100, -16'sd50, 16'sd7);
		send_word(ACT_START, '0, '0, '0);
		send_word(ACT_SAMPLE, 16'sh7fff, 16'sh8000, 16'sd10);
		send_word(ACT_SAMPLE, 16'sh8000, 16'sh7fff, 16'sd10);
		send_word(ACT_FINISH, '0, '0, '0);
		send_word(ACT_SAMPLE, 16'sh7fff, 16'sh8000, 16'sd10);
		// One axis spans a lot, two barely move: large scales saturate.
		sweep(0);
		send_word(ACT_START, '0, '0, '0);
		send_word(ACT_SAMPLE, 16'sh7fff, 16'sd0, 16'sd0);
		send_word(ACT_SAMPLE, 16'sh8000, 16'sd1, 16'sd1);
		send_word(ACT_FINISH, '0, '0, '0);
		send_word(ACT_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh8000);

		set_range(1'b1);
		send_word(ACT_SAMPLE, 16'sh7fff, 16'sh8000, 16'sd3);
		random_phase(300);

		// Hold the receiver off while the sender keeps offering words.
		hold_off <= 1'b1;
		fork
			begin
				repeat (12) send_word(ACT_SAMPLE, pick_raw(), pick_raw(), pick_raw());
				in_valid <= 1'b0;
			end
			begin
				repeat (2000) @(negedge clk);
				hold_off <= 1'b0;
			end
		join

		send_gap_pct = 54;
		random_phase(300);
		set_range(1'b0);
		send_gap_pct = 0;
		stall_pct = 54;
		random_phase(300);
		set_range(1'b1);
		send_gap_pct = 22;
		stall_pct = 22;
		random_phase(300);
		set_range(1'b0);
		send_gap_pct = 0;
		stall_pct = 0;
		random_phase(700);

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (errors == 0) begin
			$display("** magnetometer_hard_soft_iron_calibration: PASSED **");
		end else begin
			$display("** magnetometer_hard_soft_iron_calibration: FAILED **");
		end
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+sv
sv/mhsi_pkg.sv
sv/mhsi_front.sv
sv/mhsi_div.sv
sv/mhsi_back.sv
sv/magnetometer_hard_soft_iron_calibration.sv
tb/mhsi_checker.sv
tb/tb_top.sv
